/* design/gnbd_pkg.sv */
`timescale 1ns / 1ps

package gnbd_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned LIMIT_W = 10;
    localparam int unsigned COUNT_W = 10;
    localparam int unsigned REM_W   = 11;
    localparam int unsigned MODE_W  = 3;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 10;

    localparam logic [MODE_W-1:0] MODE_HUNT  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SYNC1 = 3'd1;
    localparam logic [MODE_W-1:0] MODE_LENHI = 3'd2;
    localparam logic [MODE_W-1:0] MODE_LENLO = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DATA  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_TEXT  = 3'd5;

    localparam logic KIND_TEXT = 1'b0;
    localparam logic KIND_BIN  = 1'b1;

    localparam logic [1:0] ST_INSIDE = 2'd0;
    localparam logic [1:0] ST_DONE   = 2'd1;
    localparam logic [1:0] ST_ABORT  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_START  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_END_FIRST   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_END_SECOND  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LIMIT = 3'd5;

    localparam logic [BYTE_W-1:0]  RST_TEXT_START  = 8'd36;
    localparam logic [BYTE_W-1:0]  RST_SYNC_FIRST  = 8'd160;
    localparam logic [BYTE_W-1:0]  RST_SYNC_SECOND = 8'd161;
    localparam logic [BYTE_W-1:0]  RST_END_FIRST   = 8'd13;
    localparam logic [BYTE_W-1:0]  RST_END_SECOND  = 8'd10;
    localparam logic [LIMIT_W-1:0] RST_FRAME_LIMIT = 10'd234;

    // trailer: checksum plus two end bytes
    localparam logic [REM_W-1:0] BIN_TRAILER = 11'd3;

    typedef struct packed {
        logic [BYTE_W-1:0]  text_start_byte;
        logic [BYTE_W-1:0]  sync_first_byte;
        logic [BYTE_W-1:0]  sync_second_byte;
        logic [BYTE_W-1:0]  end_first_byte;
        logic [BYTE_W-1:0]  end_second_byte;
        logic [LIMIT_W-1:0] frame_limit;
    } cfg_t;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data_byte;
        logic              frame_kind;
        logic [1:0]        frame_status;
        logic              frame_end;
    } result_t;

endpackage

/* design/gps_nmea_binary_deframer_core.sv */
`timescale 1ns / 1ps
// Each result is registered into the output register, or the skid entry on a stall.
// Throughput: one byte per cycle unless in_stall; the parse state updates once per byte.
// Output register plus one skid entry; in_stall is high only while the skid entry is full.
// Reset: registers to defaults ($, A0, A1, CR, LF, limit 234), parser hunting, outputs empty.

module gps_nmea_binary_deframer_core
    import gnbd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [BYTE_W-1:0]     rx_byte,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [BYTE_W-1:0]     data_byte,
    output logic                  frame_kind,
    output logic [1:0]            frame_status,
    output logic                  frame_end
);

    cfg_t    cfg_reg;
    result_t res;
    result_t out_reg;
    result_t skid_reg;
    logic    out_valid_reg;
    logic    skid_valid_reg;
    logic    accept;
    logic    out_take;

    assign in_stall = skid_valid_reg;
    assign accept   = in_valid && !skid_valid_reg;
    assign out_take = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.text_start_byte  <= RST_TEXT_START;
            cfg_reg.sync_first_byte  <= RST_SYNC_FIRST;
            cfg_reg.sync_second_byte <= RST_SYNC_SECOND;
            cfg_reg.end_first_byte   <= RST_END_FIRST;
            cfg_reg.end_second_byte  <= RST_END_SECOND;
            cfg_reg.frame_limit      <= RST_FRAME_LIMIT;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_TEXT_START:  cfg_reg.text_start_byte  <= cfg_data[BYTE_W-1:0];
                CFG_SYNC_FIRST:  cfg_reg.sync_first_byte  <= cfg_data[BYTE_W-1:0];
                CFG_SYNC_SECOND: cfg_reg.sync_second_byte <= cfg_data[BYTE_W-1:0];
                CFG_END_FIRST:   cfg_reg.end_first_byte   <= cfg_data[BYTE_W-1:0];
                CFG_END_SECOND:  cfg_reg.end_second_byte  <= cfg_data[BYTE_W-1:0];
                CFG_FRAME_LIMIT: cfg_reg.frame_limit      <= cfg_data[LIMIT_W-1:0];
                default:         ;
            endcase
        end
    end

    gnbd_fsm u_fsm
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (rx_byte),
        .cfg     (cfg_reg),
        .res     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept && res.valid)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (accept && res.valid)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_reg <= res;
            end
            else
            begin
                out_reg <= res;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign data_byte    = out_reg.data_byte;
    assign frame_kind   = out_reg.frame_kind;
    assign frame_status = out_reg.frame_status;
    assign frame_end    = out_reg.frame_end;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register empty");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && !out_stall |=> !skid_valid_reg && out_valid_reg)
        else $error("skid entry not moved to output on transfer");

    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> out_valid_reg)
        else $error("stalled result dropped");

endmodule

/* design/gnbd_fsm.sv */
`timescale 1ns / 1ps

module gnbd_fsm
    import gnbd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [BYTE_W-1:0] rx_byte,
    input  cfg_t              cfg,
    output result_t           res
);

    logic [MODE_W-1:0]  mode_reg, mode_next;
    logic [COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic [BYTE_W-1:0]  len_hi_reg, len_hi_next;
    logic [BYTE_W-1:0]  prev_byte_reg, prev_byte_next;
    logic [REM_W-1:0]   rem_reg, rem_next;

    logic [15:0]        len_word;
    logic [REM_W-1:0]   rem_dec;
    logic               text_done;

    assign len_word    = {len_hi_reg, rx_byte};
    assign rem_dec     = (rem_reg != '0) ? rem_reg - 1'b1 : rem_reg;
    assign text_done   = (rx_byte == cfg.end_second_byte) && (byte_count_reg != '0)
                         && (prev_byte_reg == cfg.end_first_byte);

    always_comb
    begin
        mode_next       = mode_reg;
        byte_count_next = byte_count_reg;
        len_hi_next     = len_hi_reg;
        prev_byte_next  = prev_byte_reg;
        rem_next        = rem_reg;
        res.valid        = 1'b1;
        res.data_byte    = rx_byte;
        res.frame_kind   = KIND_BIN;
        res.frame_status = ST_INSIDE;
        res.frame_end    = 1'b0;
        unique case (mode_reg)
            MODE_SYNC1:
            begin
                if (rx_byte == cfg.sync_second_byte)
                begin
                    mode_next = MODE_LENHI;
                end
                else
                begin
                    mode_next        = MODE_HUNT;
                    res.frame_status = ST_ABORT;
                    res.frame_end    = 1'b1;
                end
            end
            MODE_LENHI:
            begin
                len_hi_next = rx_byte;
                mode_next   = MODE_LENLO;
            end
            MODE_LENLO:
            begin
                if (len_word > {6'd0, cfg.frame_limit})
                begin
                    mode_next        = MODE_HUNT;
                    res.frame_status = ST_ABORT;
                    res.frame_end    = 1'b1;
                end
                else
                begin
                    rem_next  = len_word[REM_W-1:0] + BIN_TRAILER;
                    mode_next = MODE_DATA;
                end
            end
            MODE_DATA:
            begin
                rem_next = rem_dec;
                if (rem_dec == '0)
                begin
                    mode_next        = MODE_HUNT;
                    res.frame_status = ST_DONE;
                    res.frame_end    = 1'b1;
                end
            end
            MODE_TEXT:
            begin
                res.frame_kind = KIND_TEXT;
                if (byte_count_reg >= cfg.frame_limit)
                begin
                    mode_next        = MODE_HUNT;
                    res.frame_status = ST_ABORT;
                    res.frame_end    = 1'b1;
                end
                else
                begin
                    byte_count_next = byte_count_reg + 1'b1;
                    prev_byte_next  = rx_byte;
                    if (text_done)
                    begin
                        mode_next        = MODE_HUNT;
                        res.frame_status = ST_DONE;
                        res.frame_end    = 1'b1;
                    end
                end
            end
            default:
            begin
                mode_next       = MODE_HUNT;
                byte_count_next = '0;
                len_hi_next     = '0;
                if (rx_byte == cfg.text_start_byte)
                begin
                    mode_next       = MODE_TEXT;
                    byte_count_next = COUNT_W'(1);
                    prev_byte_next  = rx_byte;
                    res.frame_kind  = KIND_TEXT;
                end
                else if (rx_byte == cfg.sync_first_byte)
                begin
                    mode_next = MODE_SYNC1;
                end
                else
                begin
                    res.valid = 1'b0;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_HUNT;
            byte_count_reg <= '0;
            len_hi_reg     <= '0;
            prev_byte_reg  <= '0;
            rem_reg        <= '0;
        end
        else if (accept)
        begin
            mode_reg       <= mode_next;
            byte_count_reg <= byte_count_next;
            len_hi_reg     <= len_hi_next;
            prev_byte_reg  <= prev_byte_next;
            rem_reg        <= rem_next;
        end
    end

    a_data_rem_live: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_DATA |-> rem_reg != '0)
        else $error("binary frame in progress with nothing remaining");

    a_text_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_TEXT |-> byte_count_reg != '0)
        else $error("text sentence in progress with zero byte count");

    a_end_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        accept && res.valid && res.frame_end |=> mode_reg == MODE_HUNT)
        else $error("frame closed but parser not hunting");

    a_last_bin_byte: assert property (@(posedge clk) disable iff (!rst_n)
        accept && mode_reg == MODE_DATA && rem_reg == REM_W'(1)
        |-> res.frame_status == ST_DONE && res.frame_end)
        else $error("last binary byte not marked done");

endmodule

/* tb/sv/tb_gps_nmea_binary_deframer_core.sv */
`timescale 1ns / 1ps

module tb_gps_nmea_binary_deframer_core;
    import gnbd_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              kind;
        logic [1:0]        status;
        logic              closes;
    } frame_out_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [BYTE_W-1:0]     rx_byte;
    logic                  out_valid;
    logic                  out_stall;
    logic [BYTE_W-1:0]     data_byte;
    logic                  frame_kind;
    logic [1:0]            frame_status;
    logic                  frame_end;

    // model state and register copy
    cfg_t                  cfg;
    logic [MODE_W-1:0]     pmode;
    logic [COUNT_W-1:0]    txt_cnt;
    logic [15:0]           pay_len;
    logic [BYTE_W-1:0]     prev_txt;
    logic [REM_W-1:0]      bin_left;

    frame_out_t            pending_out[$];
    int                    produced;
    int                    errors;
    int                    cycle_count;
    int                    hold_left;
    bit                    idle_on;

    gps_nmea_binary_deframer_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .data_byte    (data_byte),
        .frame_kind   (frame_kind),
        .frame_status (frame_status),
        .frame_end    (frame_end)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_gps_nmea_binary_deframer_core NOT OK");
            $finish;
        end
    end

    // receiver: random stall, or a counted hold-off
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
        begin
            out_stall <= idle_on && ($urandom_range(0, 99) < 18);
        end
    end

    function automatic bit deframe_byte(input logic [BYTE_W-1:0] b, output frame_out_t r);
        bit got;
        bit done;
        got = 1'b1;
        r = '0;
        case (pmode)
            MODE_SYNC1:
            begin
                if (b == cfg.sync_second_byte)
                begin
                    pmode = MODE_LENHI;
                    r = '{b, KIND_BIN, ST_INSIDE, 1'b0};
                end
                else
                begin
                    pmode = MODE_HUNT;
                    r = '{b, KIND_BIN, ST_ABORT, 1'b1};
                end
            end
            MODE_LENHI:
            begin
                pay_len = {b, 8'h00};
                pmode = MODE_LENLO;
                r = '{b, KIND_BIN, ST_INSIDE, 1'b0};
            end
            MODE_LENLO:
            begin
                pay_len = pay_len | {8'h00, b};
                if (pay_len > {6'd0, cfg.frame_limit})
                begin
                    pmode = MODE_HUNT;
                    r = '{b, KIND_BIN, ST_ABORT, 1'b1};
                end
                else
                begin
                    bin_left = pay_len[REM_W-1:0] + BIN_TRAILER;
                    pmode = MODE_DATA;
                    r = '{b, KIND_BIN, ST_INSIDE, 1'b0};
                end
            end
            MODE_DATA:
            begin
                if (bin_left != 0)
                    bin_left--;
                if (bin_left == 0)
                begin
                    pmode = MODE_HUNT;
                    r = '{b, KIND_BIN, ST_DONE, 1'b1};
                end
                else
                begin
                    r = '{b, KIND_BIN, ST_INSIDE, 1'b0};
                end
            end
            MODE_TEXT:
            begin
                if (txt_cnt >= cfg.frame_limit)
                begin
                    pmode = MODE_HUNT;
                    r = '{b, KIND_TEXT, ST_ABORT, 1'b1};
                end
                else
                begin
                    done = (b == cfg.end_second_byte) && (txt_cnt != 0) &&
                           (prev_txt == cfg.end_first_byte);
                    txt_cnt++;
                    prev_txt = b;
                    if (done)
                    begin
                        pmode = MODE_HUNT;
                        r = '{b, KIND_TEXT, ST_DONE, 1'b1};
                    end
                    else
                    begin
                        r = '{b, KIND_TEXT, ST_INSIDE, 1'b0};
                    end
                end
            end
            default:
            begin
                pmode = MODE_HUNT;
                txt_cnt = '0;
                pay_len = '0;
                if (b == cfg.text_start_byte)
                begin
                    pmode = MODE_TEXT;
                    txt_cnt = COUNT_W'(1);
                    prev_txt = b;
                    r = '{b, KIND_TEXT, ST_INSIDE, 1'b0};
                end
                else if (b == cfg.sync_first_byte)
                begin
                    pmode = MODE_SYNC1;
                    r = '{b, KIND_BIN, ST_INSIDE, 1'b0};
                end
                else
                begin
                    got = 1'b0;
                end
            end
        endcase
        return got;
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        frame_out_t r;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 99) < 18)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (deframe_byte(b, r))
        begin
            pending_out.push_back(r);
            produced++;
        end
    endtask

    task automatic send_bytes(input logic [BYTE_W-1:0] bs[$]);
        foreach (bs[i])
            send_byte(bs[i]);
    endtask

    // drop valid and let every pending transfer drain
    task automatic quiesce();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_out.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_TEXT_START:  cfg.text_start_byte  = val[BYTE_W-1:0];
            CFG_SYNC_FIRST:  cfg.sync_first_byte  = val[BYTE_W-1:0];
            CFG_SYNC_SECOND: cfg.sync_second_byte = val[BYTE_W-1:0];
            CFG_END_FIRST:   cfg.end_first_byte   = val[BYTE_W-1:0];
            CFG_END_SECOND:  cfg.end_second_byte  = val[BYTE_W-1:0];
            CFG_FRAME_LIMIT: cfg.frame_limit      = val[LIMIT_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic write_all_regs(input logic [BYTE_W-1:0] ts, input logic [BYTE_W-1:0] s1,
                                  input logic [BYTE_W-1:0] s2, input logic [BYTE_W-1:0] e1,
                                  input logic [BYTE_W-1:0] e2, input logic [LIMIT_W-1:0] lim);
        // spare upper bits of byte registers get random junk
        write_reg(CFG_TEXT_START,  {2'($urandom), ts});
        write_reg(CFG_SYNC_FIRST,  {2'($urandom), s1});
        write_reg(CFG_SYNC_SECOND, {2'($urandom), s2});
        write_reg(CFG_END_FIRST,   {2'($urandom), e1});
        write_reg(CFG_END_SECOND,  {2'($urandom), e2});
        write_reg(CFG_FRAME_LIMIT, lim);
    endtask

    // mostly well-formed frames with random content, some broken ones and noise
    task automatic run_traffic(input int n_results);
        int goal;
        int pick;
        int len;
        int lim;
        logic [15:0] blen;
        goal = produced + n_results;
        lim = cfg.frame_limit;
        while (produced < goal)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                if (lim <= 60 && $urandom_range(0, 99) < 15)
                    len = lim + $urandom_range(0, 3);
                else
                    len = $urandom_range(0, lim < 30 ? lim : 30);
                send_byte(cfg.text_start_byte);
                repeat (len)
                    send_byte($urandom_range(0, 9) == 0 ? 8'($urandom)
                                                        : 8'($urandom_range(32, 126)));
                send_byte(cfg.end_first_byte);
                send_byte(cfg.end_second_byte);
            end
            else if (pick < 80)
            begin
                send_byte(cfg.sync_first_byte);
                send_byte(cfg.sync_second_byte);
                if ($urandom_range(0, 9) == 0)
                    blen = 16'($urandom);
                else
                    blen = 16'($urandom_range(0, lim < 24 ? lim : 24));
                send_byte(blen[15:8]);
                send_byte(blen[7:0]);
                if (blen <= lim)
                    repeat (blen + 3)
                        send_byte(8'($urandom));
            end
            else if (pick < 90)
            begin
                if ($urandom_range(0, 1) == 1)
                begin
                    send_byte(cfg.sync_first_byte);
                    send_byte(8'($urandom));
                end
                else
                begin
                    send_byte(cfg.text_start_byte);
                    repeat ($urandom_range(0, 4))
                        send_byte(8'($urandom));
                end
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                    send_byte(8'($urandom));
            end
        end
    endtask

    // text sentence, noise outside frames, binary frame with one payload byte
    task automatic test_basic_frames();
        send_bytes('{8'h00, 8'h24, 8'h47, 8'h0D, 8'h0A,
                     8'hA0, 8'hA1, 8'h00, 8'h01, 8'h5A, 8'hC3, 8'h0D, 8'h0A});
    endtask

    // bad second sync byte, then a length above the limit
    task automatic test_binary_aborts();
        send_bytes('{8'hA0, 8'hA0, 8'hA0, 8'hA1, 8'h01, 8'h00});
    endtask

    task automatic test_zero_limit();
        quiesce();
        write_reg(CFG_FRAME_LIMIT, '0);
        send_bytes('{8'h24, 8'h58, 8'hA0, 8'hA1, 8'h00, 8'h00, 8'h11, 8'h0D, 8'h0A});
    endtask

    // start byte doubles as sync byte and as first end byte
    task automatic test_start_priority();
        quiesce();
        write_all_regs(8'hA0, 8'hA0, RST_SYNC_SECOND, 8'hA0, 8'hFF, RST_FRAME_LIMIT);
        send_bytes('{8'hA0, 8'hFF});
    endtask

    task automatic test_random_configs();
        quiesce();
        write_all_regs(RST_TEXT_START, RST_SYNC_FIRST, RST_SYNC_SECOND,
                       RST_END_FIRST, RST_END_SECOND, RST_FRAME_LIMIT);
        run_traffic(50);
        quiesce();
        write_all_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                       8'($urandom), 10'($urandom_range(1, 60)));
        run_traffic(50);
        quiesce();
        write_all_regs(8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF, 10'd1);
        run_traffic(40);
        quiesce();
        write_all_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                       8'($urandom), 10'($urandom_range(1, 1023)));
        run_traffic(50);
    endtask

    task automatic test_no_idle();
        quiesce();
        idle_on = 1'b0;
        write_all_regs(RST_TEXT_START, RST_SYNC_FIRST, RST_SYNC_SECOND,
                       RST_END_FIRST, RST_END_SECOND, 10'd1023);
        run_traffic(100);
        idle_on = 1'b1;
    endtask

    // largest binary frame, length one past the limit, sentence running over the limit
    task automatic test_long_frames();
        quiesce();
        write_all_regs(RST_TEXT_START, RST_SYNC_FIRST, RST_SYNC_SECOND,
                       RST_END_FIRST, RST_END_SECOND, 10'd1023);
        send_bytes('{8'hA0, 8'hA1, 8'h03, 8'hFF});
        repeat (1026)
            send_byte(8'($urandom));
        send_bytes('{8'hA0, 8'hA1, 8'h04, 8'h00});
        quiesce();
        write_reg(CFG_FRAME_LIMIT, 10'd20);
        send_byte(RST_TEXT_START);
        repeat (20)
            send_byte(8'($urandom_range(65, 90)));
    endtask

    // receiver holds off while the sender keeps offering a long frame
    task automatic test_backpressure();
        quiesce();
        idle_on = 1'b0;
        hold_left = 100;
        send_bytes('{8'hA0, 8'hA1, 8'h00, 8'h3C});
        repeat (63)
            send_byte(8'($urandom));
        idle_on = 1'b1;
    endtask

    always @(posedge clk)
    begin
        frame_out_t got;
        frame_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{data_byte, frame_kind, frame_status, frame_end};
            if (pending_out.size() == 0)
            begin
                $display("%0t: unexpected result data=%h kind=%0d status=%0d end=%0d",
                         $time, got.data, got.kind, got.status, got.closes);
                errors++;
            end
            else
            begin
                want = pending_out.pop_front();
                if (got !== want)
                begin
                    $display("%0t: mismatch expected data=%h kind=%0d status=%0d end=%0d",
                             $time, want.data, want.kind, want.status, want.closes);
                    $display("%0t:          actual   data=%h kind=%0d status=%0d end=%0d",
                             $time, got.data, got.kind, got.status, got.closes);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        rx_byte   = '0;
        out_stall = 1'b0;
        idle_on   = 1'b1;
        hold_left = 0;
        produced  = 0;
        errors    = 0;
        cycle_count = 0;
        cfg = '{RST_TEXT_START, RST_SYNC_FIRST, RST_SYNC_SECOND,
                RST_END_FIRST, RST_END_SECOND, RST_FRAME_LIMIT};
        pmode    = MODE_HUNT;
        txt_cnt  = '0;
        pay_len  = '0;
        prev_txt = '0;
        bin_left = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_basic_frames();
        test_binary_aborts();
        test_zero_limit();
        test_start_priority();
        test_backpressure();
        test_random_configs();
        test_no_idle();
        test_long_frames();

        quiesce();
        repeat (8) @(posedge clk);
        if (errors == 0 && pending_out.size() == 0)
            $display("tb_gps_nmea_binary_deframer_core OK");
        else
            $display("tb_gps_nmea_binary_deframer_core NOT OK");
        $finish;
    end

endmodule
